@@ rtl/core/pmtu_pkg.sv @@
// Shared types, constants and character helpers for the packed message text unpacker.
package pmtu_pkg;

  localparam int CODE_W    = 28;
  localparam int GRID_W    = 16;
  localparam int CHAR_W    = 7;
  localparam int SYM_W     = 6;
  localparam int MAX_CHARS = 14;
  localparam int LEN_W     = 4;
  localparam int DIGITS    = 5;
  localparam int SYMS      = DIGITS + 1;
  localparam int STEP_W    = 3;

  // Reciprocal divide: q = (x * floor(2^SHIFT / d)) >> SHIFT is q or q - 1
  localparam int RECIP_SHIFT = 34;
  localparam int RECIP_W     = 31;
  localparam int PROD_W      = CODE_W + RECIP_W;
  localparam int QUO_W       = PROD_W - RECIP_SHIFT;

  localparam logic [RECIP_W-1:0] RECIP_10 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd10);
  localparam logic [RECIP_W-1:0] RECIP_27 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd27);
  localparam logic [RECIP_W-1:0] RECIP_36 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd36);
  localparam logic [RECIP_W-1:0] RECIP_37 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd37);
  localparam logic [RECIP_W-1:0] RECIP_42 = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd42);

  localparam logic [CODE_W-1:0] CQ_CODE     = 28'd262177561;
  localparam logic [CODE_W-1:0] SUFFIX_LOW  = 28'd267649090;
  localparam logic [CODE_W-1:0] SUFFIX_HIGH = 28'd267698374;

  localparam logic [SYM_W-1:0] SYM_LETTER_OFS = 6'd10;

  localparam logic [CHAR_W-1:0] ASC_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] ASC_PLUS  = 7'h2B;
  localparam logic [CHAR_W-1:0] ASC_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] ASC_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] ASC_SLASH = 7'h2F;
  localparam logic [CHAR_W-1:0] ASC_QMARK = 7'h3F;
  localparam logic [CHAR_W-1:0] ASC_0     = 7'h30;
  localparam logic [CHAR_W-1:0] ASC_9     = 7'h39;
  localparam logic [CHAR_W-1:0] ASC_A     = 7'h41;
  localparam logic [CHAR_W-1:0] ASC_C     = 7'h43;
  localparam logic [CHAR_W-1:0] ASC_D     = 7'h44;
  localparam logic [CHAR_W-1:0] ASC_E     = 7'h45;
  localparam logic [CHAR_W-1:0] ASC_Q     = 7'h51;
  localparam logic [CHAR_W-1:0] ASC_X     = 7'h58;
  localparam logic [CHAR_W-1:0] ASC_Z     = 7'h5A;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = 1;
  localparam int QUEUE_CW    = 2;

  typedef enum logic [1:0] {
    KIND_TEXT   = 2'd0,
    KIND_CQ     = 2'd1,
    KIND_CQ_SFX = 2'd2,
    KIND_CALLS  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    RADIX_10,
    RADIX_27,
    RADIX_36,
    RADIX_37,
    RADIX_42
  } radix_t;

  typedef enum logic [1:0] {
    LANE_CALL,
    LANE_TEXT,
    LANE_SFX
  } lane_mode_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_MUL,
    FS_FIX,
    FS_PUSH
  } front_state_t;

  typedef struct packed {
    logic              load;
    logic              mul;
    logic              fix;
    logic [STEP_W-1:0] step;
  } lane_ctl_t;

  typedef logic [SYMS-1:0][SYM_W-1:0]        sym_vec_t;
  typedef logic [MAX_CHARS-1:0][CHAR_W-1:0]  text_t;

  typedef struct packed {
    text_t            chars;
    logic [LEN_W-1:0] len;
    kind_t            kind;
  } msg_t;

  function automatic radix_t step_radix(input lane_mode_t mode, input logic [STEP_W-1:0] step);
    radix_t r;
    unique case (mode)
      LANE_CALL: begin
        priority if (step < 3'd3) r = RADIX_27;
        else if (step == 3'd3)    r = RADIX_10;
        else                      r = RADIX_36;
      end
      LANE_TEXT: r = RADIX_42;
      LANE_SFX:  r = RADIX_37;
      default:   r = RADIX_42;
    endcase
    return r;
  endfunction

  function automatic logic [SYM_W-1:0] radix_div(input radix_t r);
    logic [SYM_W-1:0] d;
    unique case (r)
      RADIX_10: d = 6'd10;
      RADIX_27: d = 6'd27;
      RADIX_36: d = 6'd36;
      RADIX_37: d = 6'd37;
      RADIX_42: d = 6'd42;
      default:  d = 6'd42;
    endcase
    return d;
  endfunction

  function automatic logic [RECIP_W-1:0] radix_recip(input radix_t r);
    logic [RECIP_W-1:0] m;
    unique case (r)
      RADIX_10: m = RECIP_10;
      RADIX_27: m = RECIP_27;
      RADIX_36: m = RECIP_36;
      RADIX_37: m = RECIP_37;
      RADIX_42: m = RECIP_42;
      default:  m = RECIP_42;
    endcase
    return m;
  endfunction

  // 0-9 digits, 10-35 letters, 37-41 punctuation, 36 and anything above 41 is a space
  function automatic logic [CHAR_W-1:0] sym_to_ascii(input logic [SYM_W-1:0] v);
    logic [CHAR_W-1:0] c;
    priority if (v <= 6'd9) c = CHAR_W'(v) + ASC_0;
    else if (v < 6'd36)     c = CHAR_W'(v) - 7'd10 + ASC_A;
    else if (v == 6'd37)    c = ASC_PLUS;
    else if (v == 6'd38)    c = ASC_MINUS;
    else if (v == 6'd39)    c = ASC_DOT;
    else if (v == 6'd40)    c = ASC_SLASH;
    else if (v == 6'd41)    c = ASC_QMARK;
    else                    c = ASC_SPACE;
    return c;
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return (c >= ASC_A) && (c <= ASC_Z);
  endfunction

endpackage

@@ rtl/core/packed_message_text_unpacker_core.sv @@
// Top level of the packed message text unpacker.
//
// Input queue port: a 72-bit packed message (two 28-bit call codes and a
// 16-bit grid word) is taken on a clock edge with in_push high and in_full low.
// Result queue port: one ASCII character per transaction, with the message
// kind and a flag on the final character; the character on out_* is valid
// while out_empty is low and leaves on an edge with out_pop high.
// The front end decodes a message in five digit steps, each a multiply
// state and a fix state, through three parallel reciprocal-multiply lanes,
// then writes the assembled text into a two-entry queue. A new message
// is taken in the same cycle the previous one is written, so the front end
// takes a new message only once it is through with the last one. The back
// end emits one character per cycle while out_pop keeps the output register
// draining (10 to 14 characters per message).
// When out_pop stays low the output register holds, the queue fills and
// in_full rises; nothing is lost. Synchronous reset (rst_n low) empties the
// queue and output register and returns the front end to idle.
module packed_message_text_unpacker_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [pmtu_pkg::CODE_W-1:0]  in_first_call_code,
  input  logic [pmtu_pkg::CODE_W-1:0]  in_second_call_code,
  input  logic [pmtu_pkg::GRID_W-1:0]  in_grid_word,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic [pmtu_pkg::CHAR_W-1:0]  out_char_code,
  output logic [1:0]                   out_message_kind,
  output logic                         out_last_char
);
  import pmtu_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  msg_t q_wdata;
  msg_t q_rdata;

  pmtu_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_first_call_code  (in_first_call_code),
    .in_second_call_code (in_second_call_code),
    .in_grid_word        (in_grid_word),
    .q_push              (q_push),
    .q_wdata             (q_wdata),
    .q_full              (q_full)
  );

  pmtu_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  pmtu_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_rdata          (q_rdata),
    .q_pop            (q_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_char_code    (out_char_code),
    .out_message_kind (out_message_kind),
    .out_last_char    (out_last_char)
  );

endmodule

@@ rtl/core/pmtu_lane.sv @@
// Digit lane: peels base-N digits off one code word, one digit per multiply and fix step.
module pmtu_lane (
  input  logic                            clk,
  input  pmtu_pkg::lane_ctl_t             ctl,
  input  pmtu_pkg::lane_mode_t            mode,
  input  logic [pmtu_pkg::CODE_W-1:0]     load_val,
  output pmtu_pkg::sym_vec_t              syms
);
  import pmtu_pkg::*;

  lane_mode_t        mode_r;
  logic [CODE_W-1:0] x_r;
  logic [PROD_W-1:0] prod_r;
  logic [SYM_W-1:0]  dig_r [DIGITS];

  radix_t            rad;
  logic [SYM_W-1:0]  div;
  logic [QUO_W-1:0]  q_est;
  logic [QUO_W-1:0]  q_fix;
  logic [CODE_W-1:0] qd;
  logic [CODE_W-1:0] rem;
  logic              need_fix;
  logic [SYM_W-1:0]  r_fix;
  logic [SYM_W-1:0]  r_sym;

  always_comb begin
    rad      = step_radix(mode_r, ctl.step);
    div      = radix_div(rad);
    q_est    = prod_r[PROD_W-1:RECIP_SHIFT];
    qd       = CODE_W'(q_est) * CODE_W'(div);
    rem      = x_r - qd;
    // estimate is low by at most one
    need_fix = rem >= CODE_W'(div);
    r_fix    = need_fix ? SYM_W'(rem - CODE_W'(div)) : SYM_W'(rem);
    q_fix    = q_est + QUO_W'(need_fix);
    r_sym    = (rad == RADIX_27) ? r_fix + SYM_LETTER_OFS : r_fix;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      x_r    <= load_val;
      mode_r <= mode;
    end else if (ctl.fix) begin
      x_r             <= CODE_W'(q_fix);
      dig_r[ctl.step] <= r_sym;
    end
    if (ctl.mul) begin
      prod_r <= PROD_W'(x_r) * PROD_W'(radix_recip(rad));
    end
  end

  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      syms[k] = dig_r[k];
    end
    // leftover quotient is the leading callsign character
    syms[DIGITS] = x_r[SYM_W-1:0];
  end

endmodule

@@ rtl/core/pmtu_front.sv @@
// Front end: accepts a message, classifies it, runs the digit lanes and builds the text.
module pmtu_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_push,
  output logic                         in_full,
  input  logic [pmtu_pkg::CODE_W-1:0]  in_first_call_code,
  input  logic [pmtu_pkg::CODE_W-1:0]  in_second_call_code,
  input  logic [pmtu_pkg::GRID_W-1:0]  in_grid_word,
  output logic                         q_push,
  output pmtu_pkg::msg_t               q_wdata,
  input  logic                         q_full
);
  import pmtu_pkg::*;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIGITS - 1);

  front_state_t      state_r, state_nxt;
  logic [STEP_W-1:0] step_r;
  kind_t             kind_r;
  kind_t             kind_nxt;
  logic              accept;
  logic              is_text;
  lane_ctl_t         lane_ctl;

  lane_mode_t        mode0, mode1, mode2;
  logic [CODE_W-1:0] val0, val1, val2;
  sym_vec_t          s0, s1, s2;

  logic [SYMS-1:0][CHAR_W-1:0] c1, c2;
  logic [4:0][CHAR_W-1:0] t0, t1;
  logic [2:0][CHAR_W-1:0] t2, sx;
  logic              cq_rewrite;

  // Classification and lane setup
  always_comb begin
    is_text = in_grid_word[GRID_W-1];
    priority if (is_text)                           kind_nxt = KIND_TEXT;
    else if (in_first_call_code == CQ_CODE)         kind_nxt = KIND_CQ;
    else if (in_first_call_code >= SUFFIX_LOW &&
             in_first_call_code <= SUFFIX_HIGH)     kind_nxt = KIND_CQ_SFX;
    else                                            kind_nxt = KIND_CALLS;

    mode0 = is_text ? LANE_TEXT : LANE_CALL;
    mode1 = is_text ? LANE_TEXT : LANE_CALL;
    mode2 = is_text ? LANE_TEXT : LANE_SFX;
    val0  = is_text ? {1'b0, in_first_call_code[CODE_W-1:1]} : in_first_call_code;
    val1  = is_text ? {1'b0, in_second_call_code[CODE_W-1:1]} : in_second_call_code;
    val2  = is_text ? CODE_W'({in_second_call_code[0], in_first_call_code[0],
                               in_grid_word[GRID_W-2:0]})
                    : in_first_call_code - SUFFIX_LOW;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE: if (in_push) state_nxt = FS_MUL;
      FS_MUL:  state_nxt = FS_FIX;
      FS_FIX:  if (step_r == LAST_STEP) state_nxt = FS_PUSH;
               else state_nxt = FS_MUL;
      FS_PUSH: if (!q_full) state_nxt = in_push ? FS_MUL : FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_full       = !(state_r == FS_IDLE || (state_r == FS_PUSH && !q_full));
    accept        = in_push && !in_full;
    q_push        = (state_r == FS_PUSH) && !q_full;
    lane_ctl.load = accept;
    lane_ctl.mul  = (state_r == FS_MUL);
    lane_ctl.fix  = (state_r == FS_FIX);
    lane_ctl.step = step_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        step_r <= '0;
      end else if (state_r == FS_FIX) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_nxt;
    end
  end

  pmtu_lane u_lane0 (.clk(clk), .ctl(lane_ctl), .mode(mode0), .load_val(val0), .syms(s0));
  pmtu_lane u_lane1 (.clk(clk), .ctl(lane_ctl), .mode(mode1), .load_val(val1), .syms(s1));
  pmtu_lane u_lane2 (.clk(clk), .ctl(lane_ctl), .mode(mode2), .load_val(val2), .syms(s2));

  // Text assembly; digits come out least significant first
  always_comb begin
    for (int k = 0; k < SYMS; k++) begin
      c1[k] = sym_to_ascii(s0[SYMS-1-k]);
      c2[k] = sym_to_ascii(s1[SYMS-1-k]);
    end
    for (int k = 0; k < 5; k++) begin
      t0[k] = sym_to_ascii(s0[4-k]);
      t1[k] = sym_to_ascii(s1[4-k]);
    end
    for (int k = 0; k < 3; k++) begin
      t2[k] = sym_to_ascii(s2[2-k]);
      sx[k] = sym_to_ascii(s2[k]);
    end

    // "CQ9DX " and " E9xy " both become "CQ " plus call chars 3 and 4
    cq_rewrite = (c1[0] == ASC_C && c1[1] == ASC_Q && c1[2] == ASC_9 &&
                  c1[3] == ASC_D && c1[4] == ASC_X && c1[5] == ASC_SPACE) ||
                 (c1[0] == ASC_SPACE && c1[1] == ASC_E && c1[2] == ASC_9 &&
                  is_alpha(c1[3]) && is_alpha(c1[4]) && c1[5] == ASC_SPACE);

    q_wdata.chars = '{default: ASC_SPACE};
    q_wdata.kind  = kind_r;
    q_wdata.len   = LEN_W'(MAX_CHARS);
    unique case (kind_r)
      KIND_TEXT: begin
        for (int k = 0; k < 5; k++) begin
          q_wdata.chars[k]     = t0[k];
          q_wdata.chars[5 + k] = t1[k];
        end
        for (int k = 0; k < 3; k++) begin
          q_wdata.chars[10 + k] = t2[k];
        end
        q_wdata.len = 4'd13;
      end
      KIND_CQ, KIND_CQ_SFX: begin
        q_wdata.chars[0] = ASC_C;
        q_wdata.chars[1] = ASC_Q;
        for (int k = 0; k < SYMS; k++) begin
          q_wdata.chars[3 + k] = c2[k];
        end
        if (kind_r == KIND_CQ_SFX) begin
          q_wdata.chars[9] = ASC_SLASH;
          for (int k = 0; k < 3; k++) begin
            q_wdata.chars[10 + k] = sx[k];
          end
          q_wdata.len = 4'd14;
        end else begin
          q_wdata.len = 4'd10;
        end
      end
      KIND_CALLS: begin
        if (cq_rewrite) begin
          q_wdata.chars[0] = ASC_C;
          q_wdata.chars[1] = ASC_Q;
          q_wdata.chars[3] = c1[3];
          q_wdata.chars[4] = c1[4];
          for (int k = 0; k < SYMS; k++) begin
            q_wdata.chars[6 + k] = c2[k];
          end
          q_wdata.len = 4'd13;
        end else begin
          for (int k = 0; k < SYMS; k++) begin
            q_wdata.chars[k]     = c1[k];
            q_wdata.chars[7 + k] = c2[k];
          end
          q_wdata.len = 4'd14;
        end
      end
      default: q_wdata.len = LEN_W'(MAX_CHARS);
    endcase
  end

endmodule

@@ rtl/core/pmtu_fifo.sv @@
// Two-entry message queue between the front and back ends.
module pmtu_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  pmtu_pkg::msg_t  wdata,
  output logic            full,
  input  logic            pop,
  output pmtu_pkg::msg_t  rdata,
  output logic            empty
);
  import pmtu_pkg::*;

  msg_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;
  logic                do_push;
  logic                do_pop;

  assign full    = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule

@@ rtl/core/pmtu_back.sv @@
// Back end: streams the characters of queued messages into the output register.
module pmtu_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_empty,
  input  pmtu_pkg::msg_t               q_rdata,
  output logic                         q_pop,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic [pmtu_pkg::CHAR_W-1:0]  out_char_code,
  output logic [1:0]                   out_message_kind,
  output logic                         out_last_char
);
  import pmtu_pkg::*;

  msg_t              cur_r;
  logic              busy_r;
  logic [LEN_W-1:0]  idx_r;
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  kind_t             out_kind_r;
  logic              out_last_r;

  logic              adv;
  logic              take;
  logic              is_last;

  always_comb begin
    adv     = !out_valid_r || out_pop;
    take    = busy_r && adv;
    is_last = (idx_r == cur_r.len - 1'b1);
    // next message loads as the last character of the current one leaves
    q_pop   = !q_empty && (!busy_r || (take && is_last));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        idx_r  <= '0;
      end else if (take && is_last) begin
        busy_r <= 1'b0;
      end else if (take) begin
        idx_r <= idx_r + 1'b1;
      end
      if (adv) begin
        out_valid_r <= busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_rdata;
    end
    if (take) begin
      out_char_r <= cur_r.chars[idx_r];
      out_kind_r <= cur_r.kind;
      out_last_r <= is_last;
    end
  end

  assign out_empty        = !out_valid_r;
  assign out_char_code    = out_char_r;
  assign out_message_kind = out_kind_r;
  assign out_last_char    = out_last_r;

endmodule

@@ tb/tb.sv @@
// Testbench for packed_message_text_unpacker_core: randomized messages checked char by char.
`timescale 1ns / 1ps

module tb;
  import pmtu_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_ITEMS  = 147;
  localparam int HOLD_AFTER    = 400;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 40;
  localparam int IDLE_PCT      = 24;

  typedef logic [5:0][CHAR_W-1:0] call_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    kind_t             kind;
    logic              last;
  } char_item_t;

  class text_scoreboard;
    char_item_t        expected_chars[$];
    logic [CHAR_W-1:0] text_buf[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      errors  = 0;
      checked = 0;
    endfunction

    function logic [CHAR_W-1:0] sym_char(int unsigned v);
      string punct;
      punct = " +-./?";
      if (v <= 9) return ASC_0 + CHAR_W'(v);
      if (v < 36) return ASC_A + CHAR_W'(v - 10);
      if (v < 42) return CHAR_W'(punct[v - 36]);
      return ASC_SPACE;
    endfunction

    // Read from the right: three base-27 letters, a digit, a base-36 alnum, then the rest
    function call_t decode_call(int unsigned code);
      call_t c;
      for (int i = 5; i >= 3; i--) begin
        c[i] = sym_char(code % 27 + 10);
        code = code / 27;
      end
      c[2] = sym_char(code % 10);
      code = code / 10;
      c[1] = sym_char(code % 36);
      code = code / 36;
      c[0] = sym_char(code);
      return c;
    endfunction

    function void add_text(string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(CHAR_W'(s[i]));
    endfunction

    function void add_call(call_t c);
      for (int i = 0; i < 6; i++) text_buf.push_back(c[i]);
    endfunction

    // Works out the characters one accepted message must produce
    function void note_message(logic [CODE_W-1:0] a, logic [CODE_W-1:0] b,
                               logic [GRID_W-1:0] g);
      kind_t             kind;
      int unsigned       x;
      int unsigned       y;
      int unsigned       t;
      int unsigned       n;
      call_t             c1;
      call_t             c2;
      logic [CHAR_W-1:0] free_text [13];
      logic [CHAR_W-1:0] sfx [3];
      char_item_t        item;

      text_buf.delete();
      if (g[15]) begin
        kind = KIND_TEXT;
        t = {15'd0, b[0], a[0], g[14:0]};
        x = a >> 1;
        y = b >> 1;
        for (int i = 4; i >= 0; i--) begin
          free_text[i] = sym_char(x % 42);
          x = x / 42;
        end
        for (int i = 9; i >= 5; i--) begin
          free_text[i] = sym_char(y % 42);
          y = y / 42;
        end
        for (int i = 12; i >= 10; i--) begin
          free_text[i] = sym_char(t % 42);
          t = t / 42;
        end
        for (int i = 0; i < 13; i++) text_buf.push_back(free_text[i]);
      end else if (a == CQ_CODE) begin
        kind = KIND_CQ;
        add_text("CQ ");
        add_call(decode_call(b));
        add_text(" ");
      end else if (a >= SUFFIX_LOW && a <= SUFFIX_HIGH) begin
        kind = KIND_CQ_SFX;
        n = a - SUFFIX_LOW;
        // suffix digits come out least significant first
        for (int i = 0; i < 3; i++) begin
          sfx[i] = sym_char(n % 37);
          n = n / 37;
        end
        add_text("CQ ");
        add_call(decode_call(b));
        add_text("/");
        for (int i = 0; i < 3; i++) text_buf.push_back(sfx[i]);
        add_text(" ");
      end else begin
        kind = KIND_CALLS;
        c1 = decode_call(a);
        c2 = decode_call(b);
        if (c1[0] == ASC_C && c1[1] == ASC_Q && c1[2] == ASC_9 && c1[3] == ASC_D &&
            c1[4] == ASC_X && c1[5] == ASC_SPACE) begin
          add_text("CQ DX");
        end else if (c1[0] == ASC_SPACE && c1[1] == ASC_E && c1[2] == ASC_9 &&
                     c1[3] >= ASC_A && c1[3] <= ASC_Z &&
                     c1[4] >= ASC_A && c1[4] <= ASC_Z && c1[5] == ASC_SPACE) begin
          add_text("CQ ");
          text_buf.push_back(c1[3]);
          text_buf.push_back(c1[4]);
        end else begin
          add_call(c1);
        end
        add_text(" ");
        add_call(c2);
        add_text(" ");
      end

      foreach (text_buf[i]) begin
        item.ch   = text_buf[i];
        item.kind = kind;
        item.last = (i == text_buf.size() - 1);
        expected_chars.push_back(item);
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] ch, logic [1:0] kind, logic last);
      char_item_t want;
      checked++;
      if (expected_chars.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected char %02h kind %0d last %0b", $realtime, ch, kind, last);
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch || kind !== want.kind || last !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("%0t: mismatch exp char %02h kind %0d last %0b, got %02h %0d %0b",
                   $realtime, want.ch, want.kind, want.last, ch, kind, last);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                in_push;
  logic                in_full;
  logic [CODE_W-1:0]   in_first_call_code;
  logic [CODE_W-1:0]   in_second_call_code;
  logic [GRID_W-1:0]   in_grid_word;
  logic                out_pop;
  logic                out_empty;
  logic [CHAR_W-1:0]   out_char_code;
  logic [1:0]          out_message_kind;
  logic                out_last_char;

  text_scoreboard sb = new();
  bit             calm;
  int unsigned    cycle_count;

  packed_message_text_unpacker_core u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_first_call_code  (in_first_call_code),
    .in_second_call_code (in_second_call_code),
    .in_grid_word        (in_grid_word),
    .out_pop             (out_pop),
    .out_empty           (out_empty),
    .out_char_code       (out_char_code),
    .out_message_kind    (out_message_kind),
    .out_last_char       (out_last_char)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** packed_message_text_unpacker_core: FAILED **");
      $finish;
    end
  end

  // lead is the raw leading symbol, letters are 0-25 with 26 for a space
  function automatic logic [CODE_W-1:0] call_code(int unsigned lead, int unsigned alnum,
                                                  int unsigned digit, int unsigned l1,
                                                  int unsigned l2, int unsigned l3);
    return CODE_W'(((((lead * 36 + alnum) * 10 + digit) * 27 + l1) * 27 + l2) * 27 + l3);
  endfunction

  task automatic send_message(input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b,
                              input logic [GRID_W-1:0] g);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push             <= 1'b1;
    in_first_call_code  <= a;
    in_second_call_code <= b;
    in_grid_word        <= g;
    do @(posedge clk); while (in_full);
    sb.note_message(a, b, g);
  endtask

  // Receiver: random pops, plus one long hold-off so the block backs up into in_full
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty)
        sb.check_char(out_char_code, out_message_kind, out_last_char);
      if (!held && sb.checked >= HOLD_AFTER) begin
        held      = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    logic [CODE_W-1:0] a;
    logic [CODE_W-1:0] b;
    logic [GRID_W-1:0] g;
    int unsigned       sel;

    calm                = 0;
    rst_n               <= 1'b0;
    in_push             <= 1'b0;
    in_first_call_code  <= '0;
    in_second_call_code <= '0;
    in_grid_word        <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // free text corners, including the call-code low bits feeding the third group
    send_message(28'd0, 28'd0, 16'h8000);
    send_message(28'hFFFFFFF, 28'hFFFFFFF, 16'hFFFF);
    send_message(28'd1, 28'd0, 16'h8000);
    send_message(28'd0, 28'd1, 16'h8000);
    send_message(CQ_CODE, 28'h5A5A5A5, 16'h8000);
    // plain CQ, grid ignored
    send_message(CQ_CODE, 28'd0, 16'h0000);
    send_message(CQ_CODE, 28'hFFFFFFF, 16'h7FFF);
    // suffix range edges and just outside
    send_message(SUFFIX_LOW, 28'd123456, 16'h1234);
    send_message(SUFFIX_HIGH, 28'hFFFFFFF, 16'h0000);
    send_message(SUFFIX_LOW + 28'd24680, 28'd99999999, 16'h4321);
    send_message(SUFFIX_LOW - 28'd1, 28'd5, 16'h0000);
    send_message(SUFFIX_HIGH + 28'd1, 28'd77, 16'h0000);
    send_message(CQ_CODE - 28'd1, 28'd0, 16'h0000);
    send_message(CQ_CODE + 28'd1, 28'd0, 16'h0000);
    // CQ DX rewrite and a near miss
    send_message(call_code(12, 26, 9, 3, 23, 26), 28'd314159, 16'h0000);
    send_message(call_code(12, 26, 9, 3, 23, 0), 28'd314159, 16'h0000);
    send_message(call_code(12, 26, 9, 3, 23, 26), 28'd314159, 16'h8000);
    // E9 rewrite with letters, near misses with spaces
    send_message(call_code(36, 14, 9, 0, 1, 26), 28'd2718281, 16'h0000);
    send_message(call_code(36, 14, 9, 25, 25, 26), 28'd2718281, 16'h0000);
    send_message(call_code(36, 14, 9, 0, 26, 26), 28'd2718281, 16'h0000);
    send_message(call_code(36, 14, 9, 26, 4, 26), 28'd2718281, 16'h0000);
    // two plain calls at the extremes
    send_message(28'd0, 28'd0, 16'h0000);
    send_message(28'hFFFFFFF, 28'hFFFFFFF, 16'h7FFF);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= 60 && k < 100);
      sel  = $urandom_range(99);
      a    = CODE_W'($urandom);
      b    = CODE_W'($urandom);
      g    = GRID_W'($urandom);
      if (sel < 25) begin
        g[15] = 1'b1;
      end else begin
        g[15] = 1'b0;
        if (sel < 40)
          a = CQ_CODE;
        else if (sel < 55)
          a = CODE_W'($urandom_range(SUFFIX_HIGH, SUFFIX_LOW));
        else if (sel < 63)
          a = call_code(12, 26, 9, 3, 23, ($urandom_range(3) == 0) ? $urandom_range(26) : 26);
        else if (sel < 73)
          a = call_code(36, 14, 9, $urandom_range(26), $urandom_range(26),
                        ($urandom_range(3) == 0) ? $urandom_range(26) : 26);
      end
      send_message(a, b, g);
    end
    calm = 0;
    in_push <= 1'b0;

    while (sb.expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.expected_chars.size() == 0) begin
      $display("** packed_message_text_unpacker_core: PASSED **");
    end else begin
      $display("** packed_message_text_unpacker_core: FAILED **");
    end
    $finish;
  end

endmodule
